[rtl/rba_pkg.sv]
`default_nettype none
package rba_pkg;

    // Pool geometry
    localparam int POOL_BLOCKS = 1024;
    localparam int ID_W        = 10;
    localparam int DEPTH_W     = ID_W + 1;
    localparam int MAX_ALLOC   = 64;
    localparam int CNT_W       = 7;
    localparam int REF_BITS    = 8;

    // Port field widths
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int REF_OUT_W   = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [REF_BITS-1:0] rc_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam rc_t RC_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_SHARE = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED = 3'd0,
        STAT_OOM     = 3'd1,
        STAT_DONE    = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_SAT     = 3'd4,
        STAT_NONE    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_ALLOC,
        CTL_WAIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        PEND_GRANT,
        PEND_RMW,
        PEND_DIRECT
    } pend_kind_t;

    // Free stack port
    typedef struct packed {
        logic we;
        id_t  waddr;
        id_t  wdata;
        logic re;
        id_t  raddr;
    } stack_req_t;

    // Reference count memory port
    typedef struct packed {
        logic we;
        id_t  waddr;
        rc_t  wdata;
        logic re;
        id_t  raddr;
    } rc_req_t;

    // One result item
    typedef struct packed {
        id_t     id;
        rc_t     rc;
        depth_t  free_cnt;
        status_t status;
        logic    last;
    } result_t;

endpackage
`default_nettype wire

[rtl/rba_stack_mem.sv]
`default_nettype none
module rba_stack_mem
(
    input  logic                   clk,
    input  rba_pkg::stack_req_t    req,
    output rba_pkg::id_t           rdata
);

    rba_pkg::id_t mem [rba_pkg::POOL_BLOCKS];
    rba_pkg::id_t rdata_reg;

    // Free stack storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/rba_rc_mem.sv]
`default_nettype none
module rba_rc_mem
(
    input  logic                clk,
    input  rba_pkg::rc_req_t    req,
    output rba_pkg::rc_t        rdata
);

    rba_pkg::rc_t mem [rba_pkg::POOL_BLOCKS];
    rba_pkg::rc_t rdata_reg;

    // Per-block reference counts, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/rba_ctrl.sv]
`default_nettype none
module rba_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rba_pkg::func_t         in_func,
    input  rba_pkg::id_t           in_id,
    input  rba_pkg::cnt_t          in_cnt,
    input  logic                   out_free,
    output logic                   res_valid,
    output rba_pkg::result_t       res,
    output rba_pkg::stack_req_t    stack_req,
    input  rba_pkg::id_t           stack_rdata,
    output rba_pkg::rc_req_t       rc_req,
    input  rba_pkg::rc_t           rc_rdata
);

    rba_pkg::ctl_state_t state_reg, state_next;
    rba_pkg::id_t        clr_addr_reg, clr_addr_next;
    rba_pkg::depth_t     depth_reg, depth_next;
    rba_pkg::depth_t     low_reg, low_next;
    rba_pkg::cnt_t       remain_reg, remain_next;

    // Pending item whose memory read data is now on the read port
    logic                pend_valid_reg, pend_valid_next;
    rba_pkg::pend_kind_t pend_kind_reg, pend_kind_next;
    rba_pkg::func_t      pend_func_reg, pend_func_next;
    rba_pkg::id_t        pend_id_reg, pend_id_next;
    rba_pkg::depth_t     pend_depth_reg, pend_depth_next;
    logic                pend_use_idx_reg, pend_use_idx_next;
    logic                pend_last_reg, pend_last_next;
    rba_pkg::status_t    pend_status_reg, pend_status_next;

    logic            accept;
    logic            consume;
    logic            issue;
    logic            in_clear;
    logic            in_alloc;
    logic            cnt_zero;
    logic            cnt_over;
    logic            cnt_oom;
    logic            alloc_ok;
    logic            id_bad;
    rba_pkg::depth_t depth_m1;
    rba_pkg::id_t    grant_blk;
    rba_pkg::rc_t    rc_dec;
    rba_pkg::rc_t    rc_inc;

    // Decode of the incoming item
    assign accept   = in_valid && in_ready;
    assign consume  = pend_valid_reg && out_free;
    assign cnt_zero = (in_cnt == '0);
    assign cnt_over = (in_cnt > rba_pkg::CNT_W'(rba_pkg::MAX_ALLOC));
    assign cnt_oom  = ({{(rba_pkg::DEPTH_W - rba_pkg::CNT_W){1'b0}}, in_cnt} > depth_reg);
    assign alloc_ok = !cnt_zero && !cnt_over && !cnt_oom;
    assign id_bad   = ({1'b0, in_id} >= rba_pkg::DEPTH_W'(rba_pkg::POOL_BLOCKS));
    assign depth_m1 = depth_reg - 1'b1;
    assign issue    = in_alloc && (!pend_valid_reg || consume);

    // Pop data below the low-water mark was never overwritten: it is the index
    assign grant_blk = pend_use_idx_reg ? pend_id_reg : stack_rdata;
    assign rc_dec    = rc_rdata - 1'b1;
    assign rc_inc    = rc_rdata + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rba_pkg::CTL_CLEAR:
            begin
                if (clr_addr_reg == rba_pkg::ID_W'(rba_pkg::POOL_BLOCKS - 1))
                begin
                    state_next = rba_pkg::CTL_IDLE;
                end
            end
            rba_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == rba_pkg::FUNC_ALLOC && alloc_ok)
                    begin
                        state_next = rba_pkg::CTL_ALLOC;
                    end
                    else
                    begin
                        state_next = rba_pkg::CTL_WAIT;
                    end
                end
            end
            rba_pkg::CTL_ALLOC:
            begin
                if (issue && remain_reg == rba_pkg::CNT_W'(1))
                begin
                    state_next = rba_pkg::CTL_WAIT;
                end
            end
            rba_pkg::CTL_WAIT:
            begin
                if (consume)
                begin
                    state_next = rba_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = rba_pkg::CTL_IDLE;
            end
        endcase
    end

    // State decoded outputs
    always_comb
    begin
        in_ready = 1'b0;
        in_clear = 1'b0;
        in_alloc = 1'b0;
        case (state_reg)
            rba_pkg::CTL_CLEAR: in_clear = 1'b1;
            rba_pkg::CTL_IDLE:  in_ready = 1'b1;
            rba_pkg::CTL_ALLOC: in_alloc = 1'b1;
            rba_pkg::CTL_WAIT:  in_ready = 1'b0;
            default:            in_ready = 1'b0;
        endcase
    end

    // Datapath: memory requests, result and register updates
    always_comb
    begin
        clr_addr_next     = clr_addr_reg;
        depth_next        = depth_reg;
        low_next          = low_reg;
        remain_next       = remain_reg;
        pend_valid_next   = pend_valid_reg && !consume;
        pend_kind_next    = pend_kind_reg;
        pend_func_next    = pend_func_reg;
        pend_id_next      = pend_id_reg;
        pend_depth_next   = pend_depth_reg;
        pend_use_idx_next = pend_use_idx_reg;
        pend_last_next    = pend_last_reg;
        pend_status_next  = pend_status_reg;

        stack_req = '0;
        rc_req    = '0;
        res_valid = consume;
        res       = '0;

        // Count memory clearing pass after reset
        if (in_clear)
        begin
            rc_req.we     = 1'b1;
            rc_req.waddr  = clr_addr_reg;
            rc_req.wdata  = '0;
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        // New item
        if (accept)
        begin
            pend_func_next   = in_func;
            pend_id_next     = in_id;
            pend_last_next   = 1'b1;
            pend_status_next = rba_pkg::STAT_IGNORED;
            if (in_func == rba_pkg::FUNC_ALLOC)
            begin
                pend_id_next = '0;
                if (alloc_ok)
                begin
                    remain_next = in_cnt;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_kind_next  = rba_pkg::PEND_DIRECT;
                    if (cnt_zero)
                    begin
                        pend_status_next = rba_pkg::STAT_NONE;
                    end
                    else if (cnt_over)
                    begin
                        pend_status_next = rba_pkg::STAT_IGNORED;
                    end
                    else
                    begin
                        pend_status_next = rba_pkg::STAT_OOM;
                    end
                end
            end
            else if (id_bad)
            begin
                pend_valid_next = 1'b1;
                pend_kind_next  = rba_pkg::PEND_DIRECT;
            end
            else
            begin
                rc_req.re       = 1'b1;
                rc_req.raddr    = in_id;
                pend_valid_next = 1'b1;
                pend_kind_next  = rba_pkg::PEND_RMW;
            end
        end

        // Pop one block per cycle during an allocate, unless the output register is stalled
        if (issue)
        begin
            stack_req.re      = 1'b1;
            stack_req.raddr   = depth_m1[rba_pkg::ID_W-1:0];
            depth_next        = depth_m1;
            low_next          = (depth_m1 < low_reg) ? depth_m1 : low_reg;
            remain_next       = remain_reg - 1'b1;
            pend_valid_next   = 1'b1;
            pend_kind_next    = rba_pkg::PEND_GRANT;
            pend_id_next      = depth_m1[rba_pkg::ID_W-1:0];
            pend_use_idx_next = (depth_m1 < low_reg);
            pend_depth_next   = depth_m1;
            pend_last_next    = (remain_reg == rba_pkg::CNT_W'(1));
        end

        // Finish the pending item: write back and form the result
        case (pend_kind_reg)
            rba_pkg::PEND_GRANT:
            begin
                res.id       = grant_blk;
                res.rc       = rba_pkg::REF_BITS'(1);
                res.free_cnt = pend_depth_reg;
                res.status   = rba_pkg::STAT_GRANTED;
                res.last     = pend_last_reg;
                if (consume)
                begin
                    rc_req.we    = 1'b1;
                    rc_req.waddr = grant_blk;
                    rc_req.wdata = rba_pkg::REF_BITS'(1);
                end
            end
            rba_pkg::PEND_RMW:
            begin
                res.id       = pend_id_reg;
                res.rc       = rc_rdata;
                res.free_cnt = depth_reg;
                res.status   = rba_pkg::STAT_DONE;
                res.last     = 1'b1;
                if (pend_func_reg == rba_pkg::FUNC_QUERY)
                begin
                    res.status = rba_pkg::STAT_DONE;
                end
                else if (rc_rdata == '0)
                begin
                    res.status = rba_pkg::STAT_IGNORED;
                end
                else if (pend_func_reg == rba_pkg::FUNC_FREE)
                begin
                    res.rc = rc_dec;
                    if (consume)
                    begin
                        rc_req.we    = 1'b1;
                        rc_req.waddr = pend_id_reg;
                        rc_req.wdata = rc_dec;
                    end
                    // Last reference gone: push the block back
                    if (rc_dec == '0 && depth_reg < rba_pkg::DEPTH_W'(rba_pkg::POOL_BLOCKS))
                    begin
                        res.free_cnt = depth_reg + 1'b1;
                        if (consume)
                        begin
                            stack_req.we    = 1'b1;
                            stack_req.waddr = depth_reg[rba_pkg::ID_W-1:0];
                            stack_req.wdata = pend_id_reg;
                            depth_next      = depth_reg + 1'b1;
                        end
                    end
                end
                else if (rc_rdata == rba_pkg::RC_MAX)
                begin
                    res.status = rba_pkg::STAT_SAT;
                end
                else
                begin
                    res.rc = rc_inc;
                    if (consume)
                    begin
                        rc_req.we    = 1'b1;
                        rc_req.waddr = pend_id_reg;
                        rc_req.wdata = rc_inc;
                    end
                end
            end
            rba_pkg::PEND_DIRECT:
            begin
                res.id       = pend_id_reg;
                res.rc       = '0;
                res.free_cnt = depth_reg;
                res.status   = pend_status_reg;
                res.last     = 1'b1;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rba_pkg::CTL_CLEAR;
            clr_addr_reg   <= '0;
            depth_reg      <= rba_pkg::DEPTH_W'(rba_pkg::POOL_BLOCKS);
            low_reg        <= rba_pkg::DEPTH_W'(rba_pkg::POOL_BLOCKS);
            remain_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            depth_reg      <= depth_next;
            low_reg        <= low_next;
            remain_reg     <= remain_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Pending item payload
    always_ff @(posedge clk)
    begin
        pend_kind_reg    <= pend_kind_next;
        pend_func_reg    <= pend_func_next;
        pend_id_reg      <= pend_id_next;
        pend_depth_reg   <= pend_depth_next;
        pend_use_idx_reg <= pend_use_idx_next;
        pend_last_reg    <= pend_last_next;
        pend_status_reg  <= pend_status_next;
    end

endmodule
`default_nettype wire

[rtl/refcounted_block_allocator_unit.sv]
// Free, share and query read the count memory into the pending item, then the output
// register; rejected requests go straight to the pending item. Allocate of n blocks:
// one block per cycle while the output is not stalled, set by one free-stack read per cycle;
// the next item is taken after the last block. A single-result item is finished (count
// memory read, then write back) before the next is taken. Reset: asynchronous, active low;
// then a pass clears the count memory, during which s_axis_tready stays low.
`default_nettype none
module refcounted_block_allocator_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] id, [16:10] count, [23:17] zero
    input  logic [rba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [rba_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [9:0] result id, [17:10] refs, [28:18] free_count, [31:29] zero
    output logic [rba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [2:0] status
    output logic [rba_pkg::STATUS_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic                   out_free;
    logic                   res_valid;
    rba_pkg::result_t       res;
    rba_pkg::stack_req_t    stack_req;
    rba_pkg::id_t           stack_rdata;
    rba_pkg::rc_req_t       rc_req;
    rba_pkg::rc_t           rc_rdata;

    logic                   out_valid_reg;
    rba_pkg::result_t       out_reg;

    rba_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (rba_pkg::func_t'(s_axis_tuser)),
        .in_id       (s_axis_tdata[rba_pkg::ID_W-1:0]),
        .in_cnt      (s_axis_tdata[rba_pkg::ID_W +: rba_pkg::CNT_W]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .stack_req   (stack_req),
        .stack_rdata (stack_rdata),
        .rc_req      (rc_req),
        .rc_rdata    (rc_rdata)
    );

    rba_stack_mem u_stack_mem
    (
        .clk   (clk),
        .req   (stack_req),
        .rdata (stack_rdata)
    );

    rba_rc_mem u_rc_mem
    (
        .clk   (clk),
        .req   (rc_req),
        .rdata (rc_rdata)
    );

    // Output register, refilled in the cycle it is taken
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.free_cnt,
                            rba_pkg::REF_OUT_W'(out_reg.rc), out_reg.id};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 188;

    // One row of the directed stimulus; want is used only when typed is set
    typedef struct packed {
        rba_pkg::func_t   func;
        rba_pkg::id_t     id;
        rba_pkg::cnt_t    cnt;
        logic             typed;
        rba_pkg::result_t want;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rba_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [rba_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rba_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [rba_pkg::STATUS_W-1:0]    m_axis_tuser;
    logic                            m_axis_tlast;

    // Predicted pool state
    rba_pkg::id_t     pool_ids [rba_pkg::POOL_BLOCKS];
    rba_pkg::depth_t  pool_depth;
    rba_pkg::rc_t     ref_cnt [rba_pkg::POOL_BLOCKS];
    rba_pkg::result_t due_results [$];

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    refcounted_block_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic void add_result(rba_pkg::id_t id, rba_pkg::rc_t rc,
                                       rba_pkg::status_t st, logic last);
        rba_pkg::result_t r;
        r.id       = id;
        r.rc       = rc;
        r.free_cnt = pool_depth;
        r.status   = st;
        r.last     = last;
        due_results.insert(due_results.size(), r);
    endfunction

    // Apply one accepted item to the predicted pool and queue its results.
    // Every 10-bit id is a valid block here, so no range check is needed.
    function automatic void predict_results(rba_pkg::func_t f, rba_pkg::id_t id,
                                            rba_pkg::cnt_t n);
        rba_pkg::rc_t c;
        rba_pkg::id_t b;
        int           i;
        if (f == rba_pkg::FUNC_ALLOC)
        begin
            if (n == 0)
                add_result('0, '0, rba_pkg::STAT_NONE, 1'b1);
            else if (n > rba_pkg::MAX_ALLOC)
                add_result('0, '0, rba_pkg::STAT_IGNORED, 1'b1);
            else if (n > pool_depth)
                add_result('0, '0, rba_pkg::STAT_OOM, 1'b1);
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    pool_depth = pool_depth - 1'b1;
                    b = pool_ids[pool_depth];
                    ref_cnt[b] = rba_pkg::rc_t'(1);
                    add_result(b, rba_pkg::rc_t'(1), rba_pkg::STAT_GRANTED, i == n - 1);
                end
            end
            return;
        end
        c = ref_cnt[id];
        if (f == rba_pkg::FUNC_QUERY)
            add_result(id, c, rba_pkg::STAT_DONE, 1'b1);
        else if (c == 0)
            add_result(id, '0, rba_pkg::STAT_IGNORED, 1'b1);
        else if (f == rba_pkg::FUNC_FREE)
        begin
            c = c - 1'b1;
            ref_cnt[id] = c;
            // block goes back on top of the stack when its last holder drops it
            if (c == 0 && pool_depth < rba_pkg::POOL_BLOCKS)
            begin
                pool_ids[pool_depth] = id;
                pool_depth = pool_depth + 1'b1;
            end
            add_result(id, c, rba_pkg::STAT_DONE, 1'b1);
        end
        else if (c == rba_pkg::RC_MAX)
            add_result(id, c, rba_pkg::STAT_SAT, 1'b1);
        else
        begin
            c = c + 1'b1;
            ref_cnt[id] = c;
            add_result(id, c, rba_pkg::STAT_DONE, 1'b1);
        end
    endfunction

    // Any block with a nonzero count, searched from a random start (the start if none is held)
    function automatic rba_pkg::id_t pick_held();
        rba_pkg::id_t start;
        int           k;
        start = rba_pkg::id_t'($urandom);
        for (k = 0; k < rba_pkg::POOL_BLOCKS; k++)
            if (ref_cnt[rba_pkg::id_t'(start + k)] != 0)
                return rba_pkg::id_t'(start + k);
        return start;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offer one item, hold it until accepted, then predict
    task automatic send_item(rba_pkg::func_t f, rba_pkg::id_t id, rba_pkg::cnt_t n,
                             logic typed, rba_pkg::result_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, n, id};
        s_axis_tuser  <= f;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_results(f, id, n);
        if (typed)
            due_results[due_results.size() - 1] = want;
    endtask

    // Stop offering until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !($urandom_range(99) < rx_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        rba_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected item: tdata %h tuser %0d tlast %0d",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("result id", want.id, m_axis_tdata[9:0]);
                check_field("refs", want.rc, m_axis_tdata[17:10]);
                check_field("free_count", want.free_cnt, m_axis_tdata[28:18]);
                check_field("status", want.status, m_axis_tuser);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t       rows [$];
        rba_pkg::func_t f;
        rba_pkg::id_t   id;
        rba_pkg::cnt_t  n;
        int             i;
        int             phase;
        int             r;

        for (i = 0; i < rba_pkg::POOL_BLOCKS; i++)
        begin
            pool_ids[i] = rba_pkg::id_t'(i);
            ref_cnt[i]  = '0;
        end
        pool_depth = rba_pkg::depth_t'(rba_pkg::POOL_BLOCKS);

        // Directed rows, sent last-listed first; typed expectations hold for that order from reset
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd960,  7'd0,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd1,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_QUERY, 10'd1000, 7'd0,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_QUERY, 10'd512,  7'd0,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd958,  7'd0,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_SHARE, 10'd960,  7'd0,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd2,   1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd64,  1'b0, '0});
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd0, 11'd1024, rba_pkg::STAT_IGNORED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd0, 11'd1024, rba_pkg::STAT_DONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd1, 11'd1023, rba_pkg::STAT_DONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_QUERY, 10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd2, 11'd1023, rba_pkg::STAT_DONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_SHARE, 10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd2, 11'd1023, rba_pkg::STAT_DONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd1,   1'b1,
                          '{10'd1023, 8'd1, 11'd1023, rba_pkg::STAT_GRANTED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd127, 1'b1,
                          '{10'd0,    8'd0, 11'd1024, rba_pkg::STAT_IGNORED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd0,    7'd65,  1'b1,
                          '{10'd0,    8'd0, 11'd1024, rba_pkg::STAT_IGNORED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_ALLOC, 10'd1023, 7'd0,   1'b1,
                          '{10'd0,    8'd0, 11'd1024, rba_pkg::STAT_NONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_QUERY, 10'd1023, 7'd0,   1'b1,
                          '{10'd1023, 8'd0, 11'd1024, rba_pkg::STAT_DONE,    1'b1}});
        rows.push_front('{rba_pkg::FUNC_SHARE, 10'd1023, 7'd127, 1'b1,
                          '{10'd1023, 8'd0, 11'd1024, rba_pkg::STAT_IGNORED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_FREE,  10'd5,    7'd0,   1'b1,
                          '{10'd5,    8'd0, 11'd1024, rba_pkg::STAT_IGNORED, 1'b1}});
        rows.push_front('{rba_pkg::FUNC_QUERY, 10'd0,    7'd0,   1'b1,
                          '{10'd0,    8'd0, 11'd1024, rba_pkg::STAT_DONE,    1'b1}});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[k])
            send_item(rows[k].func, rows[k].id, rows[k].cnt, rows[k].typed, rows[k].want);
        drain();

        // Exhaust the pool under a long receiver hold-off, then hit out of memory
        tx_idle_pct = 17;
        rx_stall_pct = 17;
        hold_go = 1'b1;
        while (pool_depth >= rba_pkg::MAX_ALLOC)
            send_item(rba_pkg::FUNC_ALLOC, rba_pkg::id_t'($urandom),
                      rba_pkg::cnt_t'(rba_pkg::MAX_ALLOC), 1'b0, '0);
        send_item(rba_pkg::FUNC_ALLOC, '0, rba_pkg::cnt_t'(rba_pkg::MAX_ALLOC), 1'b0, '0);
        if (pool_depth != 0)
            send_item(rba_pkg::FUNC_ALLOC, '0, rba_pkg::cnt_t'(pool_depth), 1'b0, '0);
        send_item(rba_pkg::FUNC_ALLOC, '0, 7'd1, 1'b0, '0);
        drain();

        // Random traffic mostly on held blocks, four idling phases
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 71;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 71;
                end
                default:
                begin
                    tx_idle_pct = 17;
                    rx_stall_pct = 17;
                end
            endcase
            for (i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                r = $urandom_range(99);
                n = rba_pkg::cnt_t'($urandom);
                id = ($urandom_range(99) < 85) ? pick_held() : rba_pkg::id_t'($urandom);
                if (r < 25)
                begin
                    f = rba_pkg::FUNC_ALLOC;
                    r = $urandom_range(99);
                    if (r < 80)
                        n = rba_pkg::cnt_t'($urandom_range(8, 1));
                    else if (r < 90)
                        n = rba_pkg::cnt_t'($urandom_range(rba_pkg::MAX_ALLOC, 9));
                    else if (r < 95)
                        n = '0;
                    else
                        n = rba_pkg::cnt_t'($urandom_range(127, rba_pkg::MAX_ALLOC + 1));
                end
                else if (r < 60)
                    f = rba_pkg::FUNC_FREE;
                else if (r < 80)
                    f = rba_pkg::FUNC_SHARE;
                else
                    f = rba_pkg::FUNC_QUERY;
                send_item(f, id, n, 1'b0, '0);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
